// ===== design/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/ttmc_pkg.sv =====
`default_nettype none
package ttmc_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int BLOCK_BITS    = 14;
	localparam int MAX_BANKS     = 4;
	localparam int HOME_ENTRY    = 88;

	localparam int ADDR_W  = 24;
	localparam int OP_W    = 3;
	localparam int OFF_W   = 3;
	localparam int BANKS_W = 3;

	localparam int TBL_AW = $clog2(TABLE_ENTRIES);
	localparam int IDX_W  = ADDR_W - BLOCK_BITS;
	localparam int IX_W   = ((IDX_W > TBL_AW) ? IDX_W : TBL_AW) + 1;

	localparam int BANK_SHIFT = 19 - BLOCK_BITS;
	localparam int MAX_BLOCKS = MAX_BANKS << BANK_SHIFT;
	localparam int UB_RAW_W   = $clog2(MAX_BLOCKS) + 1;
	localparam int UB_W       = (UB_RAW_W > 8) ? UB_RAW_W : 8;

	localparam int BLK_W     = 7;
	localparam int POS_W     = BLK_W + BLOCK_BITS;
	localparam int RAM_BYTES = MAX_BANKS << 19;
	localparam int RAM_AW    = $clog2(RAM_BYTES);
	localparam int PC_W      = ((POS_W > RAM_AW) ? POS_W : RAM_AW) + 1;

	localparam int PF_FIRST = 32'h000a_0000 >> BLOCK_BITS;
	localparam int PF_LAST  = 32'h000e_0000 >> BLOCK_BITS;
	localparam int PF_SLOTS = PF_LAST - PF_FIRST;
	localparam int SLOT_AW  = (PF_SLOTS > 1) ? $clog2(PF_SLOTS) : 1;

	localparam logic [7:0] ENTRY_ON    = 8'h80;
	localparam logic [7:0] ENTRY_BLOCK = 8'h7f;
	localparam logic [7:0] ID_BYTE     = 8'hfe;
	localparam logic [7:0] FIXED_BYTE  = 8'h80;
	localparam logic [7:0] SPARE_RST   = 8'hff;
	localparam logic [7:0] OPEN_BUS    = 8'hff;

	localparam logic [OFF_W-1:0] OFF_ID_LO  = 3'd0;
	localparam logic [OFF_W-1:0] OFF_ID_HI  = 3'd1;
	localparam logic [OFF_W-1:0] OFF_BANKS  = 3'd2;
	localparam logic [OFF_W-1:0] OFF_ENTRY  = 3'd3;
	localparam logic [OFF_W-1:0] OFF_SPARE  = 3'd4;
	localparam logic [OFF_W-1:0] OFF_FIXED  = 3'd5;
	localparam logic [OFF_W-1:0] OFF_PTR_LO = 3'd6;
	localparam logic [OFF_W-1:0] OFF_PTR_HI = 3'd7;

	typedef enum logic [OP_W-1:0] {
		OP_REG_RD   = 3'd0,
		OP_REG_WR   = 3'd1,
		OP_MEM_RD   = 3'd2,
		OP_MEM_WR   = 3'd3,
		OP_CARD_RST = 3'd4
	} op_t;

	typedef struct packed {
		logic clear;
		logic cfg_wr;
		logic accept;
		logic exec;
		logic look;
		logic ram;
		logic scan_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_busy;
		logic need_look;
		logic need_ram;
		logic need_scan;
	} sts_t;

	function automatic logic [BANKS_W-1:0] usable_banks(input logic [BANKS_W-1:0] fb);
		if (fb == BANKS_W'(0))
			return BANKS_W'(1);
		if (fb > BANKS_W'(MAX_BANKS))
			return BANKS_W'(MAX_BANKS);
		return fb;
	endfunction

	function automatic logic [UB_W-1:0] usable_blocks(input logic [BANKS_W-1:0] banks);
		return UB_W'(banks) << BANK_SHIFT;
	endfunction

	function automatic logic [7:0] bank_map(input logic [BANKS_W-1:0] banks);
		logic [7:0] v;
		v = 8'h03;
		for (int b = 1; b < MAX_BANKS; b++)
			v = v | (((BANKS_W'(b) < banks) ? 8'h02 : 8'h03) << (b * 2));
		return v;
	endfunction

	function automatic logic entry_on(input logic [7:0] e, input logic [UB_W-1:0] ub);
		return ((e & ENTRY_ON) != 8'h00) && (UB_W'(e[BLK_W-1:0]) < ub);
	endfunction

	function automatic logic [7:0] init_entry(input logic [TBL_AW-1:0] i);
		int k;
		k = int'(i) - HOME_ENTRY;
		if (k >= 0 && k < MAX_BLOCKS)
			return ENTRY_ON | (ENTRY_BLOCK & 8'(k));
		return 8'h00;
	endfunction

endpackage
`default_nettype wire

// ===== design/ttmc_ctrl.sv =====
`default_nettype none
module ttmc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire ttmc_pkg::sts_t  sts,
	output ttmc_pkg::cmd_t       cmd
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_EXEC   = 7'b0000100,
		S_LOOK   = 7'b0001000,
		S_RAM    = 7'b0010000,
		S_RESULT = 7'b0100000,
		S_SCAN   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   scan_pend_q;
	logic   rsp_valid_q;
	logic   cfg_fire;
	logic   out_free;

	assign cfg_ready = (state_q != S_SCAN);
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign req_stall = !((state_q == S_IDLE) && !scan_pend_q);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.cfg_wr = cfg_fire;
		state_d    = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (scan_pend_q) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_look ? S_LOOK : S_RESULT;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = sts.need_ram ? S_RAM : S_RESULT;
			end
			S_RAM: begin
				cmd.ram = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!sts.scan_busy)
					state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			scan_pend_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire || (cmd.exec && sts.need_scan))
				scan_pend_q <= 1'b1;
			else if (cmd.scan_start)
				scan_pend_q <= 1'b0;
			if (cmd.load_out)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== design/ttmc_dp.sv =====
`default_nettype none
module ttmc_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ttmc_pkg::cmd_t                cmd,
	output ttmc_pkg::sts_t                     sts,
	input  wire logic [ttmc_pkg::OP_W-1:0]     op,
	input  wire logic [ttmc_pkg::OFF_W-1:0]    reg_offset,
	input  wire logic [ttmc_pkg::ADDR_W-1:0]   mem_address,
	input  wire logic [7:0]                    wr_data,
	input  wire logic [ttmc_pkg::BANKS_W-1:0]  fitted_banks,
	output logic [7:0]                         rd_data,
	output logic                               claimed,
	output logic                               card_awake
);

	localparam int TBL_AW   = ttmc_pkg::TBL_AW;
	localparam int IX_W     = ttmc_pkg::IX_W;
	localparam int UB_W     = ttmc_pkg::UB_W;
	localparam int POS_W    = ttmc_pkg::POS_W;
	localparam int PC_W     = ttmc_pkg::PC_W;
	localparam int RAM_AW   = ttmc_pkg::RAM_AW;
	localparam int SLOT_AW  = ttmc_pkg::SLOT_AW;
	localparam int PF_SLOTS = ttmc_pkg::PF_SLOTS;
	localparam int BB       = ttmc_pkg::BLOCK_BITS;
	localparam int AW       = ttmc_pkg::ADDR_W;

	// latched transaction
	logic [ttmc_pkg::OP_W-1:0]    op_q;
	logic [ttmc_pkg::OFF_W-1:0]   off_q;
	logic [AW-1:0]                addr_q;
	logic [7:0]                   data_q;

	logic [ttmc_pkg::BANKS_W-1:0] fitted_q;
	logic [7:0]                   ptr_lo_q, ptr_hi_q, spare_q;

	logic [TBL_AW-1:0]            win_first_q, win_last_q;
	logic                         win_valid_q;
	logic [PF_SLOTS-1:0]          slot_q;

	logic [TBL_AW-1:0]            clr_addr_q;
	logic                         scan_issue_q;
	logic [TBL_AW-1:0]            scan_addr_q;
	logic                         scan_chk_s1;
	logic [TBL_AW-1:0]            scan_idx_s1;

	logic [7:0]                   tbl_mem [ttmc_pkg::TABLE_ENTRIES];
	logic [7:0]                   tbl_q;
	logic [7:0]                   ram_mem [ttmc_pkg::RAM_BYTES];
	logic [7:0]                   ram_q;

	logic [7:0]                   rd_q;
	logic                         hit_q;
	logic [7:0]                   rd_data_q;
	logic                         claimed_q, awake_q;

	logic [ttmc_pkg::BANKS_W-1:0] banks;
	logic [UB_W-1:0]              ub;
	logic [7:0]                   bmap;
	logic [TBL_AW-1:0]            ptr_idx;
	logic [IX_W-1:0]              idx_x;
	logic                         in_table, in_win, in_pf, slot_hit, hit;
	logic [SLOT_AW-1:0]           slot_sel;
	logic                         is_mem, tbl_on, pos_ok, ram_go;
	logic [POS_W-1:0]             pos;
	logic [RAM_AW-1:0]            ram_addr;
	logic [TBL_AW-1:0]            tbl_raddr, tbl_waddr;
	logic [7:0]                   tbl_wdata;
	logic                         tbl_we;
	logic [7:0]                   setup_rd;
	logic [IX_W-1:0]              scan_ix;
	logic                         scan_on, scan_in_pf;
	logic [SLOT_AW-1:0]           scan_slot;

	assign banks   = ttmc_pkg::usable_banks(fitted_q);
	assign ub      = ttmc_pkg::usable_blocks(banks);
	assign bmap    = ttmc_pkg::bank_map(banks);
	assign ptr_idx = TBL_AW'({ptr_hi_q, ptr_lo_q});

	assign idx_x    = IX_W'(addr_q[AW-1:BB]);
	assign in_table = idx_x < IX_W'(ttmc_pkg::TABLE_ENTRIES);
	assign in_win   = win_valid_q && (idx_x >= IX_W'(win_first_q))
		&& (idx_x <= IX_W'(win_last_q));
	assign in_pf    = (idx_x >= IX_W'(ttmc_pkg::PF_FIRST))
		&& (idx_x < IX_W'(ttmc_pkg::PF_LAST));
	assign slot_sel = SLOT_AW'(idx_x - IX_W'(ttmc_pkg::PF_FIRST));
	assign slot_hit = in_pf && slot_q[slot_sel];
	assign hit      = in_table && (in_win || slot_hit);

	assign is_mem   = (op_q == ttmc_pkg::OP_MEM_RD) || (op_q == ttmc_pkg::OP_MEM_WR);
	assign tbl_on   = ttmc_pkg::entry_on(tbl_q, ub);
	assign pos      = {tbl_q[ttmc_pkg::BLK_W-1:0], addr_q[BB-1:0]};
	assign pos_ok   = PC_W'(pos) < PC_W'(ttmc_pkg::RAM_BYTES);
	assign ram_go   = is_mem && hit && tbl_on && pos_ok;
	assign ram_addr = RAM_AW'(pos);

	assign tbl_raddr = scan_issue_q ? scan_addr_q
		: ((op_q == ttmc_pkg::OP_REG_RD) ? ptr_idx : TBL_AW'(idx_x));
	assign tbl_we    = cmd.clear || (cmd.exec && (op_q == ttmc_pkg::OP_REG_WR)
		&& (off_q == ttmc_pkg::OFF_ENTRY));
	assign tbl_waddr = cmd.clear ? clr_addr_q : ptr_idx;
	assign tbl_wdata = cmd.clear ? ttmc_pkg::init_entry(clr_addr_q) : data_q;

	assign scan_ix    = IX_W'(scan_idx_s1);
	assign scan_on    = ttmc_pkg::entry_on(tbl_q, ub);
	assign scan_in_pf = (scan_ix >= IX_W'(ttmc_pkg::PF_FIRST))
		&& (scan_ix < IX_W'(ttmc_pkg::PF_LAST));
	assign scan_slot  = SLOT_AW'(scan_ix - IX_W'(ttmc_pkg::PF_FIRST));

	assign sts.clr_last  = (clr_addr_q == TBL_AW'(ttmc_pkg::TABLE_ENTRIES - 1));
	assign sts.scan_busy = scan_issue_q || scan_chk_s1;
	assign sts.need_look = ((op_q == ttmc_pkg::OP_REG_RD) && (off_q == ttmc_pkg::OFF_ENTRY))
		|| is_mem;
	assign sts.need_ram  = ram_go && (op_q == ttmc_pkg::OP_MEM_RD);
	assign sts.need_scan = ((op_q == ttmc_pkg::OP_REG_WR) && (off_q == ttmc_pkg::OFF_ENTRY))
		|| (op_q == ttmc_pkg::OP_CARD_RST);

	always_comb begin
		unique case (off_q) inside
			ttmc_pkg::OFF_ID_LO, ttmc_pkg::OFF_ID_HI: setup_rd = ttmc_pkg::ID_BYTE;
			ttmc_pkg::OFF_BANKS:  setup_rd = bmap;
			ttmc_pkg::OFF_ENTRY:  setup_rd = 8'h00;
			ttmc_pkg::OFF_SPARE:  setup_rd = spare_q;
			ttmc_pkg::OFF_FIXED:  setup_rd = ttmc_pkg::FIXED_BYTE;
			ttmc_pkg::OFF_PTR_LO: setup_rd = ptr_lo_q;
			ttmc_pkg::OFF_PTR_HI: setup_rd = ptr_hi_q;
			default:              setup_rd = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			off_q  <= reg_offset;
			addr_q <= mem_address;
			data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fitted_q <= ttmc_pkg::BANKS_W'(ttmc_pkg::MAX_BANKS);
			ptr_lo_q <= 8'h00;
			ptr_hi_q <= 8'h00;
			spare_q  <= ttmc_pkg::SPARE_RST;
		end else begin
			if (cmd.cfg_wr)
				fitted_q <= fitted_banks;
			if (cmd.exec && (op_q == ttmc_pkg::OP_REG_WR)) begin
				case (off_q)
					ttmc_pkg::OFF_PTR_LO: ptr_lo_q <= data_q;
					ttmc_pkg::OFF_PTR_HI: ptr_hi_q <= data_q;
					ttmc_pkg::OFF_SPARE:  spare_q  <= data_q;
					default: ;
				endcase
			end
			if (cmd.exec && (op_q == ttmc_pkg::OP_CARD_RST)) begin
				ptr_lo_q <= 8'h00;
				ptr_hi_q <= 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			scan_issue_q <= 1'b0;
			scan_addr_q  <= '0;
			scan_chk_s1  <= 1'b0;
			win_first_q  <= '0;
			win_last_q   <= '0;
			win_valid_q  <= 1'b0;
			slot_q       <= '0;
		end else begin
			if (cmd.clear)
				clr_addr_q <= clr_addr_q + TBL_AW'(1);
			scan_chk_s1 <= scan_issue_q;
			if (cmd.scan_start) begin
				scan_issue_q <= 1'b1;
				scan_addr_q  <= '0;
				win_first_q  <= '0;
				win_last_q   <= '0;
				win_valid_q  <= 1'b0;
			end else begin
				if (scan_issue_q) begin
					scan_addr_q <= scan_addr_q + TBL_AW'(1);
					if (scan_addr_q == TBL_AW'(ttmc_pkg::TABLE_ENTRIES - 1))
						scan_issue_q <= 1'b0;
				end
				if (scan_chk_s1) begin
					if (scan_on && (scan_ix >= IX_W'(ttmc_pkg::HOME_ENTRY))) begin
						if (!win_valid_q)
							win_first_q <= scan_idx_s1;
						win_last_q  <= scan_idx_s1;
						win_valid_q <= 1'b1;
					end
					if (scan_in_pf)
						slot_q[scan_slot] <= scan_on;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_addr_q;
	end

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
		tbl_q <= tbl_mem[tbl_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.look && ram_go && (op_q == ttmc_pkg::OP_MEM_WR))
			ram_mem[ram_addr] <= data_q;
		ram_q <= ram_mem[ram_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == ttmc_pkg::OP_REG_RD)
				rd_q <= setup_rd;
			else if (op_q == ttmc_pkg::OP_MEM_RD)
				rd_q <= ttmc_pkg::OPEN_BUS;
			else
				rd_q <= 8'h00;
			hit_q <= 1'b0;
		end
		if (cmd.look) begin
			if (op_q == ttmc_pkg::OP_REG_RD)
				rd_q <= tbl_q;
			hit_q <= is_mem && hit;
		end
		if (cmd.ram)
			rd_q <= ram_q;
		if (cmd.load_out) begin
			rd_data_q <= rd_q;
			claimed_q <= hit_q;
			awake_q   <= bmap[0];
		end
	end

	assign rd_data    = rd_data_q;
	assign claimed    = claimed_q;
	assign card_awake = awake_q;

endmodule
`default_nettype wire

// ===== design/translate_table_memory_card.sv =====
// channel   | handshake                        | payload
// request   | req_valid / req_stall            | op, reg_offset, mem_address, wr_data
// response  | rsp_valid / rsp_stall            | rd_data, claimed, card_awake
// config    | cfg_valid / cfg_ready            | fitted_banks
//
// One transaction at a time: register accesses pass through EXEC and RESULT; table entry
// reads and memory accesses add LOOK for the registered table read, and memory reads that
// reach card RAM add RAM for the registered RAM read. Entry writes, card resets and config
// writes add a table rescan, one entry per cycle through the table read port, before the
// next request. After reset the table is filled with its initial entries, then rescanned;
// req_stall stays high meanwhile. The response register lets the next request in while a
// stalled response waits.
`default_nettype none
module translate_table_memory_card (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [ttmc_pkg::OP_W-1:0]     op,
	input  wire logic [ttmc_pkg::OFF_W-1:0]    reg_offset,
	input  wire logic [ttmc_pkg::ADDR_W-1:0]   mem_address,
	input  wire logic [7:0]                    wr_data,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic [7:0]                         rd_data,
	output logic                               claimed,
	output logic                               card_awake,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ttmc_pkg::BANKS_W-1:0]  fitted_banks
);

	ttmc_pkg::cmd_t cmd;
	ttmc_pkg::sts_t sts;

	ttmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ttmc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.reg_offset   (reg_offset),
		.mem_address  (mem_address),
		.wr_data      (wr_data),
		.fitted_banks (fitted_banks),
		.rd_data      (rd_data),
		.claimed      (claimed),
		.card_awake   (card_awake)
	);

endmodule
`default_nettype wire

// ===== design/ttmc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module ttmc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_stall,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_stall,
	input wire logic [7:0]                    rd_data,
	input wire logic                          claimed,
	input wire logic                          card_awake
);

	logic [1:0] cnt_q;
	logic       req_fire, rsp_fire;

	assign req_fire = req_valid && !req_stall;
	assign rsp_fire = rsp_valid && !rsp_stall;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_q + {1'b0, req_fire} - {1'b0, rsp_fire};
	end

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rd_data) && $stable(claimed))
	`ASSERT_IMPL(a_awake, clk, arst_n, rsp_valid, card_awake)
	`ASSERT_IMPL(a_no_orphan, clk, arst_n, rsp_valid, cnt_q != 2'd0)
	`ASSERT_IMPL(a_depth, clk, arst_n, req_fire, cnt_q != 2'd2)

endmodule

bind translate_table_memory_card ttmc_checker u_ttmc_checker (.*);
`default_nettype wire

// ===== sim/tb_translate_table_memory_card.sv =====
`timescale 1ns / 1ps

typedef struct packed {
	logic [ttmc_pkg::OP_W-1:0]   op;
	logic [ttmc_pkg::OFF_W-1:0]  off;
	logic [ttmc_pkg::ADDR_W-1:0] addr;
	logic [7:0]                  data;
} access_t;

typedef struct packed {
	logic [7:0] rd;
	logic       hit;
	logic       awake;
} reply_t;

class card_scoreboard;
	logic [7:0]                   xlate [ttmc_pkg::TABLE_ENTRIES];
	logic [15:0]                  ptr;
	logic [7:0]                   regs [8];
	logic [7:0]                   ram [int unsigned];
	logic [ttmc_pkg::BANKS_W-1:0] banks;
	int unsigned                  win_first;
	int unsigned                  win_last;
	bit                           win_on;
	bit                           slot_on [ttmc_pkg::PF_SLOTS];
	reply_t                       due_replies [$];
	int unsigned                  errors;

	function new();
		banks = ttmc_pkg::BANKS_W'(ttmc_pkg::MAX_BANKS);
		ptr = '0;
		errors = 0;
		foreach (xlate[i])
			xlate[i] = 8'h00;
		for (int i = 0; i < int'(blocks_usable()); i++)
			if (ttmc_pkg::HOME_ENTRY + i < ttmc_pkg::TABLE_ENTRIES)
				xlate[ttmc_pkg::HOME_ENTRY + i] = ttmc_pkg::ENTRY_ON
					| (ttmc_pkg::ENTRY_BLOCK & 8'(i));
		regs = '{ttmc_pkg::ID_BYTE, ttmc_pkg::ID_BYTE, 8'h00, 8'h00, ttmc_pkg::SPARE_RST,
			ttmc_pkg::FIXED_BYTE, 8'h00, 8'h00};
		regs[ttmc_pkg::OFF_BANKS] = bank_byte();
		refresh_decode();
	endfunction

	function int unsigned banks_usable();
		if (banks == 0)
			return 1;
		if (banks > ttmc_pkg::MAX_BANKS)
			return ttmc_pkg::MAX_BANKS;
		return 32'(banks);
	endfunction

	function int unsigned blocks_usable();
		return banks_usable() << ttmc_pkg::BANK_SHIFT;
	endfunction

	function logic [7:0] bank_byte();
		logic [7:0] v;
		v = 8'h03;
		for (int b = 1; b < ttmc_pkg::MAX_BANKS; b++)
			v = v | (((b < banks_usable()) ? 8'h02 : 8'h03) << (2 * b));
		return v;
	endfunction

	function bit live(int unsigned idx);
		int unsigned blk;
		if (idx >= ttmc_pkg::TABLE_ENTRIES)
			return 0;
		blk = 32'(xlate[idx] & ttmc_pkg::ENTRY_BLOCK);
		return ((xlate[idx] & ttmc_pkg::ENTRY_ON) != 8'h00) && (blk < blocks_usable());
	endfunction

	function void refresh_decode();
		win_on = 0;
		win_first = 0;
		win_last = 0;
		for (int unsigned i = ttmc_pkg::HOME_ENTRY; i < ttmc_pkg::TABLE_ENTRIES; i++)
			if (live(i)) begin
				if (!win_on)
					win_first = i;
				win_last = i;
				win_on = 1;
			end
		foreach (slot_on[s])
			slot_on[s] = live(ttmc_pkg::PF_FIRST + s);
	endfunction

	function bit decodes(int unsigned idx);
		if (idx >= ttmc_pkg::TABLE_ENTRIES)
			return 0;
		if (win_on && idx >= win_first && idx <= win_last)
			return 1;
		if (idx >= ttmc_pkg::PF_FIRST && idx < ttmc_pkg::PF_LAST)
			return slot_on[idx - ttmc_pkg::PF_FIRST];
		return 0;
	endfunction

	function int unsigned ram_pos(logic [ttmc_pkg::ADDR_W-1:0] addr);
		int unsigned blk;
		int unsigned lo;
		blk = 32'(xlate[addr >> ttmc_pkg::BLOCK_BITS] & ttmc_pkg::ENTRY_BLOCK);
		lo = 32'(addr) & ((1 << ttmc_pkg::BLOCK_BITS) - 1);
		return (blk << ttmc_pkg::BLOCK_BITS) + lo;
	endfunction

	function bit reaches_blank_ram(logic [ttmc_pkg::ADDR_W-1:0] addr);
		int unsigned idx;
		idx = 32'(addr >> ttmc_pkg::BLOCK_BITS);
		return decodes(idx) && live(idx) && !ram.exists(ram_pos(addr));
	endfunction

	function void set_banks(logic [ttmc_pkg::BANKS_W-1:0] v);
		banks = v;
		regs[ttmc_pkg::OFF_BANKS] = bank_byte();
		refresh_decode();
	endfunction

	// returns 1 when the transaction stored a byte in card RAM
	function bit note_access(access_t a);
		reply_t      r;
		int unsigned idx;
		bit          stored;
		r = '0;
		stored = 0;
		idx = 32'(a.addr >> ttmc_pkg::BLOCK_BITS);
		case (a.op)
		ttmc_pkg::OP_REG_RD: begin
			if (a.off == ttmc_pkg::OFF_ENTRY)
				r.rd = xlate[ptr % ttmc_pkg::TABLE_ENTRIES];
			else
				r.rd = regs[a.off];
		end
		ttmc_pkg::OP_REG_WR: begin
			if (a.off != ttmc_pkg::OFF_ID_LO && a.off != ttmc_pkg::OFF_ID_HI &&
					a.off != ttmc_pkg::OFF_BANKS && a.off != ttmc_pkg::OFF_FIXED) begin
				regs[a.off] = a.data;
				if (a.off == ttmc_pkg::OFF_ENTRY) begin
					xlate[ptr % ttmc_pkg::TABLE_ENTRIES] = a.data;
					refresh_decode();
				end else if (a.off == ttmc_pkg::OFF_PTR_LO) begin
					ptr[7:0] = a.data;
				end else if (a.off == ttmc_pkg::OFF_PTR_HI) begin
					ptr[15:8] = a.data;
				end
			end
		end
		ttmc_pkg::OP_MEM_RD, ttmc_pkg::OP_MEM_WR: begin
			r.rd = (a.op == ttmc_pkg::OP_MEM_RD) ? ttmc_pkg::OPEN_BUS : 8'h00;
			if (decodes(idx)) begin
				r.hit = 1'b1;
				if (live(idx)) begin
					if (a.op == ttmc_pkg::OP_MEM_RD) begin
						r.rd = ram.exists(ram_pos(a.addr)) ? ram[ram_pos(a.addr)] : 8'h00;
					end else begin
						ram[ram_pos(a.addr)] = a.data;
						stored = 1;
					end
				end
			end
		end
		ttmc_pkg::OP_CARD_RST: begin
			ptr = '0;
			regs[ttmc_pkg::OFF_PTR_LO] = 8'h00;
			regs[ttmc_pkg::OFF_PTR_HI] = 8'h00;
			refresh_decode();
		end
		default: ;
		endcase
		r.awake = regs[ttmc_pkg::OFF_BANKS][0];
		due_replies.push_back(r);
		return stored;
	endfunction

	function void check_reply(logic [7:0] rd, logic hit, logic awake);
		reply_t e;
		if (due_replies.size() == 0) begin
			errors++;
			$error("response with no transaction pending: rd_data %02h claimed %0b", rd, hit);
			return;
		end
		e = due_replies.pop_front();
		if (rd !== e.rd) begin
			errors++;
			$error("rd_data: expected %02h, actual %02h", e.rd, rd);
		end
		if (hit !== e.hit) begin
			errors++;
			$error("claimed: expected %0b, actual %0b", e.hit, hit);
		end
		if (awake !== e.awake) begin
			errors++;
			$error("card_awake: expected %0b, actual %0b", e.awake, awake);
		end
	endfunction

	function int unsigned pending();
		return due_replies.size();
	endfunction
endclass

module tb_translate_table_memory_card;

	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned PHASE_ITEMS    = 125;
	localparam int unsigned SETTLE_CYCLES  = 20;
	localparam int unsigned RECENT_DEPTH   = 64;
	localparam logic [ttmc_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [ttmc_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	logic [ttmc_pkg::OP_W-1:0]     op;
	logic [ttmc_pkg::OFF_W-1:0]    reg_offset;
	logic [ttmc_pkg::ADDR_W-1:0]   mem_address;
	logic [7:0]                    wr_data;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic [7:0]                    rd_data;
	logic                          claimed;
	logic                          card_awake;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [ttmc_pkg::BANKS_W-1:0]  fitted_banks;

	card_scoreboard                sb;
	access_t                       plan [$];
	logic [ttmc_pkg::ADDR_W-1:0]   written_addrs [$];
	bit                            no_idle = 0;
	int unsigned                   idle_cycles = 0;
	logic [ttmc_pkg::BANKS_W-1:0]  bank_steps [8] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd4, 3'd3,
		3'd5, 3'd6};

	translate_table_memory_card u_dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void queue_access(logic [ttmc_pkg::OP_W-1:0] o,
			logic [ttmc_pkg::OFF_W-1:0] f, logic [ttmc_pkg::ADDR_W-1:0] ad, logic [7:0] d);
		access_t a;
		a.op = o;
		a.off = f;
		a.addr = ad;
		a.data = d;
		plan.push_back(a);
	endfunction

	function automatic int unsigned pick_index();
		int unsigned hi;
		case ($urandom_range(0, 9))
		0, 1, 2, 3: begin
			hi = sb.win_on ? sb.win_last + 2 : ttmc_pkg::HOME_ENTRY + 8;
			if (hi >= ttmc_pkg::TABLE_ENTRIES)
				hi = ttmc_pkg::TABLE_ENTRIES - 1;
			return $urandom_range(ttmc_pkg::HOME_ENTRY - 2, hi);
		end
		4, 5, 6: return $urandom_range(ttmc_pkg::PF_FIRST - 1, ttmc_pkg::PF_LAST);
		default: return $urandom_range(0, ttmc_pkg::TABLE_ENTRIES - 1);
		endcase
	endfunction

	function automatic logic [ttmc_pkg::ADDR_W-1:0] block_addr(int unsigned idx);
		logic [ttmc_pkg::ADDR_W-1:0] lo;
		case ($urandom_range(0, 7))
		0: lo = '0;
		1: lo = ttmc_pkg::ADDR_W'((1 << ttmc_pkg::BLOCK_BITS) - 1);
		default: lo = ttmc_pkg::ADDR_W'($urandom_range(0, (1 << ttmc_pkg::BLOCK_BITS) - 1));
		endcase
		return (ttmc_pkg::ADDR_W'(idx) << ttmc_pkg::BLOCK_BITS) | lo;
	endfunction

	function automatic logic [7:0] pick_entry();
		int unsigned ub;
		ub = sb.blocks_usable();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4, 5: return ttmc_pkg::ENTRY_ON | 8'($urandom_range(0, ub - 1));
		6: return ttmc_pkg::ENTRY_ON | 8'($urandom_range((ub < 128) ? ub : 0, 127));
		7: return 8'($urandom_range(0, 127));
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic void plan_random();
		int unsigned                 r;
		int unsigned                 idx;
		logic [7:0]                  hi_bits;
		logic [ttmc_pkg::ADDR_W-1:0] a;
		r = $urandom_range(0, 99);
		if (r < 22) begin
			queue_access(ttmc_pkg::OP_MEM_WR, ttmc_pkg::OFF_W'($urandom),
				block_addr(pick_index()), 8'($urandom));
		end else if (r < 47) begin
			if (written_addrs.size() > 0 && $urandom_range(0, 3) != 0)
				a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
			else
				a = block_addr(pick_index());
			queue_access(ttmc_pkg::OP_MEM_RD, ttmc_pkg::OFF_W'($urandom), a, 8'($urandom));
		end else if (r < 60) begin
			// program one entry through the pointer, then use its block
			idx = pick_index();
			hi_bits = ($urandom_range(0, 3) == 0) ? 8'($urandom) & 8'hfc : 8'h00;
			queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_PTR_LO,
				ttmc_pkg::ADDR_W'($urandom), 8'(idx));
			queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_PTR_HI,
				ttmc_pkg::ADDR_W'($urandom), hi_bits | 8'(idx >> 8));
			if ($urandom_range(0, 1) == 0)
				queue_access(ttmc_pkg::OP_REG_RD, ttmc_pkg::OFF_ENTRY,
					ttmc_pkg::ADDR_W'($urandom), 8'($urandom));
			queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_ENTRY,
				ttmc_pkg::ADDR_W'($urandom), pick_entry());
			repeat ($urandom_range(0, 4)) begin
				a = block_addr(idx);
				queue_access(ttmc_pkg::OP_MEM_WR, ttmc_pkg::OFF_W'($urandom), a,
					8'($urandom));
				queue_access(ttmc_pkg::OP_MEM_RD, ttmc_pkg::OFF_W'($urandom), a,
					8'($urandom));
			end
		end else if (r < 72) begin
			queue_access(ttmc_pkg::OP_REG_RD, ttmc_pkg::OFF_W'($urandom),
				ttmc_pkg::ADDR_W'($urandom), 8'($urandom));
		end else if (r < 86) begin
			queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_W'($urandom),
				ttmc_pkg::ADDR_W'($urandom), 8'($urandom));
		end else if (r < 90) begin
			queue_access(ttmc_pkg::OP_CARD_RST, ttmc_pkg::OFF_W'($urandom),
				ttmc_pkg::ADDR_W'($urandom), 8'($urandom));
		end else if (r < 94) begin
			queue_access(ttmc_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
				ttmc_pkg::OFF_W'($urandom), ttmc_pkg::ADDR_W'($urandom), 8'($urandom));
		end else begin
			queue_access(ttmc_pkg::OP_W'($urandom), ttmc_pkg::OFF_W'($urandom),
				ttmc_pkg::ADDR_W'($urandom), 8'($urandom));
		end
	endfunction

	task automatic send_access(access_t a);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		op <= a.op;
		reg_offset <= a.off;
		mem_address <= a.addr;
		wr_data <= a.data;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (sb.note_access(a)) begin
			written_addrs.push_back(a.addr);
			if (written_addrs.size() > RECENT_DEPTH)
				void'(written_addrs.pop_front());
		end
	endtask

	task automatic run_items(int unsigned count);
		access_t a;
		repeat (count) begin
			if (plan.size() == 0)
				plan_random();
			a = plan.pop_front();
			// never read card RAM that has not been written
			if (a.op == ttmc_pkg::OP_MEM_RD && sb.reaches_blank_ram(a.addr))
				a.op = ttmc_pkg::OP_MEM_WR;
			send_access(a);
		end
		plan.delete();
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_banks(logic [ttmc_pkg::BANKS_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		fitted_banks <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_banks(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned n;
		wait (arst_n === 1'b1);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 13);
			repeat (n) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
			end
			@(negedge clk);
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			sb.check_reply(rd_data, claimed, card_awake);
		end
	end

	initial begin
		logic [ttmc_pkg::ADDR_W-1:0] home_addr;
		logic [ttmc_pkg::ADDR_W-1:0] top_addr;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		op = ttmc_pkg::OP_REG_RD;
		reg_offset = '0;
		mem_address = '0;
		wr_data = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		fitted_banks = ttmc_pkg::BANKS_W'(ttmc_pkg::MAX_BANKS);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_banks(ttmc_pkg::BANKS_W'(ttmc_pkg::MAX_BANKS));

		home_addr = ttmc_pkg::ADDR_W'(ttmc_pkg::HOME_ENTRY) << ttmc_pkg::BLOCK_BITS;
		top_addr = (ttmc_pkg::ADDR_W'(ttmc_pkg::HOME_ENTRY + ttmc_pkg::MAX_BLOCKS)
			<< ttmc_pkg::BLOCK_BITS) - ttmc_pkg::ADDR_W'(1);
		for (int k = 0; k < 8; k++)
			queue_access(ttmc_pkg::OP_REG_RD, ttmc_pkg::OFF_W'(k),
				ttmc_pkg::ADDR_W'($urandom), 8'($urandom));
		queue_access(ttmc_pkg::OP_MEM_RD, ttmc_pkg::OFF_W'($urandom), '1, 8'($urandom));
		queue_access(ttmc_pkg::OP_MEM_WR, ttmc_pkg::OFF_W'($urandom), home_addr, 8'h00);
		queue_access(ttmc_pkg::OP_MEM_RD, ttmc_pkg::OFF_W'($urandom), home_addr,
			8'($urandom));
		queue_access(ttmc_pkg::OP_MEM_WR, ttmc_pkg::OFF_W'($urandom), top_addr, 8'hff);
		queue_access(ttmc_pkg::OP_MEM_RD, ttmc_pkg::OFF_W'($urandom), top_addr,
			8'($urandom));
		queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_BANKS, ttmc_pkg::ADDR_W'($urandom),
			8'h00);
		queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_FIXED, ttmc_pkg::ADDR_W'($urandom),
			8'h55);
		queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_SPARE, ttmc_pkg::ADDR_W'($urandom),
			8'h5a);
		// pointer beyond the table wraps onto the last entry, opening a hole in the window
		queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_PTR_LO, ttmc_pkg::ADDR_W'($urandom),
			8'hff);
		queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_PTR_HI, ttmc_pkg::ADDR_W'($urandom),
			8'hff);
		queue_access(ttmc_pkg::OP_REG_RD, ttmc_pkg::OFF_ENTRY, ttmc_pkg::ADDR_W'($urandom),
			8'($urandom));
		queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_ENTRY, ttmc_pkg::ADDR_W'($urandom),
			ttmc_pkg::ENTRY_ON | 8'h05);
		queue_access(ttmc_pkg::OP_MEM_RD, ttmc_pkg::OFF_W'($urandom),
			ttmc_pkg::ADDR_W'(256) << ttmc_pkg::BLOCK_BITS, 8'($urandom));
		queue_access(ttmc_pkg::OP_REG_WR, ttmc_pkg::OFF_ENTRY, ttmc_pkg::ADDR_W'($urandom),
			8'h00);
		queue_access(ttmc_pkg::OP_CARD_RST, ttmc_pkg::OFF_W'($urandom),
			ttmc_pkg::ADDR_W'($urandom), 8'($urandom));
		queue_access(ttmc_pkg::OP_REG_RD, ttmc_pkg::OFF_PTR_HI, ttmc_pkg::ADDR_W'($urandom),
			8'($urandom));
		queue_access(OP_SPARE_FIRST, ttmc_pkg::OFF_W'($urandom), ttmc_pkg::ADDR_W'($urandom),
			8'($urandom));
		queue_access(OP_SPARE_LAST, ttmc_pkg::OFF_W'($urandom), ttmc_pkg::ADDR_W'($urandom),
			8'($urandom));
		run_items(plan.size());
		drain();

		foreach (bank_steps[p]) begin
			write_banks(bank_steps[p]);
			no_idle = (p % 3 == 2);
			run_items(PHASE_ITEMS);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
